>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset.
`define RBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define RBD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Types, constants and averaging helpers of the RGB 4x4 box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 24;

  // Widest usable row, with the two low bits cleared.
  localparam logic [DIM_W-1:0] WIDTH_CAP = DIM_W'(MAX_WIDTH & ~3);

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd768;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // Row phase within a group of four rows.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  // Position of one accepted word, handed from control to datapath.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [1:0]       phase;
    logic             active;
    logic             last_col;
    logic             last_row;
  } ctl_t;

  // One scaled pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } res_t;

  // Rounded average of two bytes.
  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // Channel-wise rounded average of two packed pixels.
  function automatic logic [PIX_W-1:0] avg_px(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return {avg8(a[23:16], b[23:16]), avg8(a[15:8], b[15:8]), avg8(a[7:0], b[7:0])};
  endfunction

endpackage

>>> src/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Configuration registers and the column and row counters of the pixel stream.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic [0:0]               cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0] cfg_data,
  input  logic                     accept,
  output rbd_pkg::ctl_t            cur
);
  import rbd_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w_eff, w_mask, h_eff, full_rows;
  logic [COL_W-1:0] col;
  logic [DIM_W-1:0] row;
  logic [DIM_W:0]   col_inc, row_inc;

  // Effective frame size: width in steps of four, clamped; height at least one.
  always_comb begin
    w_mask = {width_r[DIM_W-1:2], 2'b00};
    if (w_mask == '0) begin
      w_eff = DIM_W'(4);
    end else if (w_mask > WIDTH_CAP) begin
      w_eff = WIDTH_CAP;
    end else begin
      w_eff = w_mask;
    end
    h_eff     = (height_r == '0) ? DIM_W'(1) : height_r;
    full_rows = {h_eff[DIM_W-1:2], 2'b00};
  end

  // Position of the word at the input, restarted if a setting shrank the frame.
  always_comb begin
    col     = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    row     = (row_r >= h_eff) ? '0 : row_r;
    col_inc = {2'b00, col} + (DIM_W+1)'(1);
    row_inc = {1'b0, row} + (DIM_W+1)'(1);

    cur.col      = col;
    cur.phase    = row[1:0];
    cur.active   = (row < full_rows);
    cur.last_col = (col_inc == {1'b0, w_eff});
    cur.last_row = (row_inc == {1'b0, full_rows});

    if (col_inc >= {1'b0, w_eff}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row;
    end
  end

  // Registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

>>> src/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath
// Two line stores with read-modify-write, vertical averaging and the
// horizontal four-pixel sum.
// ----------------------------------------------------------------------------
module rbd_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  rbd_pkg::ctl_t cur,
  input  logic [7:0]    red_in,
  input  logic [7:0]    green_in,
  input  logic [7:0]    blue_in,
  output logic          push,
  output rbd_pkg::res_t res
);
  import rbd_pkg::*;

  // Line stores, one word per column.
  logic [PIX_W-1:0] pair_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] third_mem [MAX_WIDTH];

  logic             s1_valid_r;
  ctl_t             ctl_r;
  logic [PIX_W-1:0] px_r, pair_rd_r, third_rd_r;
  logic [9:0]       red_sum_r, green_sum_r, blue_sum_r;
  logic [9:0]       red_sum_nxt, green_sum_nxt, blue_sum_nxt;
  logic [PIX_W-1:0] vert;
  logic             fourth_row, first_col;

  // Read stage: fetch both line entries of the incoming column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair_rd_r  <= pair_mem[cur.col];
      third_rd_r <= third_mem[cur.col];
      ctl_r      <= cur;
      px_r       <= {red_in, green_in, blue_in};
    end
  end

  // Write-back stage. A column comes back no sooner than four words later,
  // so the write always lands before the next read of the same entry.
  always_ff @(posedge clk) begin
    if (s1_valid_r && ctl_r.active) begin
      unique case (ctl_r.phase)
        PH_FIRST:  pair_mem[ctl_r.col]  <= px_r;
        PH_SECOND: pair_mem[ctl_r.col]  <= avg_px(pair_rd_r, px_r);
        PH_THIRD:  third_mem[ctl_r.col] <= px_r;
        PH_FOURTH: ;
      endcase
    end
  end

  // Vertical reduction and the running horizontal sum.
  always_comb begin
    vert       = avg_px(pair_rd_r, avg_px(third_rd_r, px_r));
    fourth_row = s1_valid_r && ctl_r.active && (ctl_r.phase == PH_FOURTH);
    first_col  = (ctl_r.col[1:0] == 2'd0);
    red_sum_nxt   = (first_col ? 10'd0 : red_sum_r)   + {2'b00, vert[23:16]};
    green_sum_nxt = (first_col ? 10'd0 : green_sum_r) + {2'b00, vert[15:8]};
    blue_sum_nxt  = (first_col ? 10'd0 : blue_sum_r)  + {2'b00, vert[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
    end else if (fourth_row) begin
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
    end
  end

  // A scaled pixel leaves on every fourth column of the fourth row.
  assign push = fourth_row && (ctl_r.col[1:0] == 2'd3);

  always_comb begin
    res.red       = red_sum_nxt[9:2];
    res.green     = green_sum_nxt[9:2];
    res.blue      = blue_sum_nxt[9:2];
    res.row_end   = ctl_r.last_col;
    res.frame_end = ctl_r.last_col && ctl_r.last_row;
  end

endmodule

>>> src/rbd_out_fifo.sv
// ----------------------------------------------------------------------------
// rbd_out_fifo
// Two-word output queue that decouples the datapath from the result channel.
// ----------------------------------------------------------------------------
module rbd_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rbd_pkg::res_t push_data,
  input  logic          out_ready,
  output logic          out_valid,
  output rbd_pkg::res_t out_data,
  output logic [1:0]    count
);
  import rbd_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      priority if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

>>> src/rgb_box_downscale_4x4_unit.sv
// ----------------------------------------------------------------------------
// rgb_box_downscale_4x4_unit
// RGB 4x4 box downscaler: raster pixels in, one averaged pixel per 4x4 block.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_red_in, in_green_in, in_blue_in
//   out     | output    | out_valid / out_ready| out_red_out .. out_frame_end
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel per cycle while in_ready is high. A pixel reads its column from the
// line stores on acceptance and writes back at the next edge; a scaled pixel is
// written into the two-word output queue at that same edge and shows on out_valid
// from then on. in_ready drops while the queue holds two words, or one word with
// a second one entering. Reset is synchronous; the line stores are not cleared.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_box_downscale_4x4_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_red_in,
  input  logic [7:0]                in_green_in,
  input  logic [7:0]                in_blue_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_red_out,
  output logic [7:0]                out_green_out,
  output logic [7:0]                out_blue_out,
  output logic                      out_row_end,
  output logic                      out_frame_end,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [rbd_pkg::DIM_W-1:0] cfg_data
);
  import rbd_pkg::*;

`include "assert_macros.svh"

  ctl_t       cur;
  res_t       push_data, out_data;
  logic       push, accept;
  logic [1:0] fifo_cnt;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Take a word only if the queue has room for the result in flight.
  assign in_ready = (fifo_cnt == 2'd0) || ((fifo_cnt == 2'd1) && !push);

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cur       (cur)
  );

  rbd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cur      (cur),
    .red_in   (in_red_in),
    .green_in (in_green_in),
    .blue_in  (in_blue_in),
    .push     (push),
    .res      (push_data)
  );

  rbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  assign out_red_out   = out_data.red;
  assign out_green_out = out_data.green;
  assign out_blue_out  = out_data.blue;
  assign out_row_end   = out_data.row_end;
  assign out_frame_end = out_data.frame_end;

  // A full queue must never take a word without draining one.
  `RBD_ASSERT(a_no_overflow, push && (fifo_cnt == 2'd2) |-> out_ready, "output queue overflow")
  // No input is taken while the queue is full.
  `RBD_NEVER(a_full_stalls, (fifo_cnt == 2'd2) && in_ready, "input taken with full queue")
  // The last pixel of a frame is also the last of its row.
  `RBD_ASSERT(a_frame_row, out_valid && out_frame_end |-> out_row_end, "frame end without row end")

endmodule

>>> dv/rgb_box_downscale_4x4_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_downscale_4x4_unit_tb
// Self-checking bench for the RGB 4x4 box downscaler. A short table of
// directed words runs first, then random frames at many widths and heights,
// including mid-row width cuts, an oversized width and heights too small to
// yield output. Every accepted pixel goes through a behavioral downscaler
// and each scaled word is compared field by field, in order.
// ----------------------------------------------------------------------------
module rgb_box_downscale_4x4_unit_tb;
  import rbd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int STAGE_WORDS = 230;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // One row of the directed table: a register write or a pixel.
  typedef struct {
    bit               is_reg;
    cfg_idx_t         idx;
    logic [DIM_W-1:0] val;
    rgb_t             px;
    bit               typed;
    res_t             want;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_red_in;
  logic [7:0]       in_green_in;
  logic [7:0]       in_blue_in;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_red_out;
  logic [7:0]       out_green_out;
  logic [7:0]       out_blue_out;
  logic             out_row_end;
  logic             out_frame_end;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [0:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  rgb_box_downscale_4x4_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Behavioral downscaler state.
  rgb_t             ab_line [MAX_WIDTH];
  rgb_t             c_line  [MAX_WIDTH];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [9:0]       acc_r;
  logic [9:0]       acc_g;
  logic [9:0]       acc_b;
  logic [DIM_W-1:0] reg_w;
  logic [DIM_W-1:0] reg_h;

  res_t        pending_scaled [$];
  plan_row_t   plan [$];
  int          mismatches;
  int unsigned sent_pixels;
  int unsigned quiet_cycles;
  int          send_idle;
  int          recv_idle;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounded mean of two bytes.
  function automatic logic [7:0] round_mean(input logic [7:0] a, input logic [7:0] b);
    return 8'((int'(a) + int'(b) + 1) >> 1);
  endfunction

  function automatic rgb_t mix_rgb(input rgb_t a, input rgb_t b);
    rgb_t m;
    m.r = round_mean(a.r, b.r);
    m.g = round_mean(a.g, b.g);
    m.b = round_mean(a.b, b.b);
    return m;
  endfunction

  // Row length in use: low bits dropped, zero taken as four, capped at the line size.
  function automatic int unsigned row_len();
    int unsigned w;
    w = int'(reg_w) & ~3;
    if (w == 0) w = 4;
    if (w > (MAX_WIDTH & ~3)) w = MAX_WIDTH & ~3;
    return w;
  endfunction

  // A raised width or a new height is only safe at the start of a row group.
  function automatic bit at_group_start();
    return (col_pos == 0) && (row_pos % 4 == 0);
  endfunction

  // Advances the downscaler by one pixel and returns the scaled word, if any.
  task automatic downscale_pixel(input rgb_t px, output bit emit, output res_t res);
    int unsigned w;
    int unsigned h;
    int unsigned full;
    int unsigned c;
    int unsigned r;
    logic [1:0]  ph;
    rgb_t        v;
    w    = row_len();
    h    = (reg_h == 0) ? 1 : reg_h;
    full = (h / 4) * 4;
    emit = 1'b0;
    res  = '0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c  = col_pos;
    r  = row_pos;
    ph = r[1:0];
    // Rows past the last full group neither store nor emit.
    if (r < full) begin
      case (ph)
        PH_FIRST: begin
          ab_line[c] = px;
        end
        PH_SECOND: begin
          ab_line[c] = mix_rgb(ab_line[c], px);
        end
        PH_THIRD: begin
          c_line[c] = px;
        end
        default: begin
          v = mix_rgb(ab_line[c], mix_rgb(c_line[c], px));
          if (c % 4 == 0) begin
            acc_r = {2'b00, v.r};
            acc_g = {2'b00, v.g};
            acc_b = {2'b00, v.b};
          end else begin
            acc_r = acc_r + {2'b00, v.r};
            acc_g = acc_g + {2'b00, v.g};
            acc_b = acc_b + {2'b00, v.b};
          end
          if (c % 4 == 3) begin
            emit          = 1'b1;
            res.red       = acc_r[9:2];
            res.green     = acc_g[9:2];
            res.blue      = acc_b[9:2];
            res.row_end   = (c + 1 == w);
            res.frame_end = (c + 1 == w) && (r + 1 == full);
          end
        end
      endcase
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Offers one pixel word, entered and left at a falling edge.
  task automatic push_pixel(input rgb_t px, input bit typed, input res_t want);
    bit   emit;
    res_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_red_in   = px.r;
    in_green_in = px.g;
    in_blue_in  = px.b;
    do @(posedge clk); while (!in_ready);
    downscale_pixel(px, emit, res);
    if (emit) pending_scaled.push_back(typed ? want : res);
    sent_pixels++;
    @(negedge clk);
  endtask

  task automatic push_random();
    push_pixel(24'($urandom), 1'b0, '0);
  endtask

  // Register write with the pipeline drained first.
  task automatic set_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    in_valid = 1'b0;
    while (pending_scaled.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) reg_w = val;
    else reg_h = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random stretch: new geometry at a group start, sometimes a mid-row
  // width cut, then pixels until the next group start.
  task automatic run_segment();
    int unsigned w;
    int unsigned target;
    int unsigned fed;
    if (at_group_start()) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0) set_reg(CFG_WIDTH, DIM_W'($urandom_range(0, 3)));
        else set_reg(CFG_WIDTH, DIM_W'($urandom_range(4, 43)));
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0:       set_reg(CFG_HEIGHT, DIM_W'($urandom_range(0, 8191)));
          1, 2:    set_reg(CFG_HEIGHT, DIM_W'($urandom_range(0, 3)));
          default: set_reg(CFG_HEIGHT, DIM_W'($urandom_range(4, 13)));
        endcase
      end
    end
    w = row_len();
    // Narrowing mid-row may leave the column past the new width.
    if (w > 4 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2 * w)) push_random();
      set_reg(CFG_WIDTH, DIM_W'($urandom_range(0, w - 1)));
      w = row_len();
    end
    target = 4 * w * $urandom_range(1, 3);
    fed    = 0;
    while (fed < target || !at_group_start()) begin
      push_random();
      fed++;
    end
  endtask

  function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    plan_row_t p;
    p = '{is_reg: 1'b1, idx: idx, val: val, px: '0, typed: 1'b0, want: '0};
    return p;
  endfunction

  function automatic plan_row_t pix_row(input rgb_t px, input bit typed, input res_t want);
    plan_row_t p;
    p = '{is_reg: 1'b0, idx: CFG_WIDTH, val: '0, px: px, typed: typed, want: want};
    return p;
  endfunction

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle);
  end

  // Result checker: each scaled word against the oldest expectation.
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_scaled.size() == 0) begin
        $display("%0t: scaled word expected none, got %0d %0d %0d row_end %0d frame_end %0d",
                 $time, out_red_out, out_green_out, out_blue_out, out_row_end,
                 out_frame_end);
        mismatches++;
      end else begin
        want = pending_scaled.pop_front();
        check_field("red", want.red, out_red_out);
        check_field("green", want.green, out_green_out);
        check_field("blue", want.blue, out_blue_out);
        check_field("row_end", 8'(want.row_end), 8'(out_row_end));
        check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgb_box_downscale_4x4_unit: mismatch");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    res_t corner;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_red_in    = '0;
    in_green_in  = '0;
    in_blue_in   = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    sent_pixels  = 0;
    quiet_cycles = 0;
    send_idle    = 11;
    recv_idle    = 52;
    reg_w        = WIDTH_RST;
    reg_h        = HEIGHT_RST;
    col_pos      = 0;
    row_pos      = 0;
    acc_r        = '0;
    acc_g        = '0;
    acc_b        = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. A zero width acts as four; a saturated magenta block
    // scales to itself and closes both row and frame.
    corner = '{red: 8'd255, green: 8'd0, blue: 8'd255, row_end: 1'b1, frame_end: 1'b1};
    plan.push_back(reg_row(CFG_WIDTH, 13'd0));
    plan.push_back(reg_row(CFG_HEIGHT, 13'd4));
    repeat (15) plan.push_back(pix_row(24'hFF00FF, 1'b0, '0));
    plan.push_back(pix_row(24'hFF00FF, 1'b1, corner));
    // Height zero acts as one row and width seven as four: no output.
    plan.push_back(reg_row(CFG_HEIGHT, 13'd0));
    plan.push_back(reg_row(CFG_WIDTH, 13'd7));
    plan.push_back(pix_row(24'h000000, 1'b0, '0));
    plan.push_back(pix_row(24'hFFFFFF, 1'b0, '0));
    plan.push_back(pix_row(24'h5A5A5A, 1'b0, '0));
    plan.push_back(pix_row(24'hA5A5A5, 1'b0, '0));
    // Tallest height setting.
    plan.push_back(reg_row(CFG_HEIGHT, 13'd8191));
    plan.push_back(pix_row(24'h010203, 1'b0, '0));
    plan.push_back(pix_row(24'hFEFDFC, 1'b0, '0));
    plan.push_back(pix_row(24'h80807F, 1'b0, '0));
    plan.push_back(pix_row(24'h7F8080, 1'b0, '0));
    foreach (plan[i]) begin
      if (plan[i].is_reg) set_reg(plan[i].idx, plan[i].val);
      else push_pixel(plan[i].px, plan[i].typed, plan[i].want);
    end

    // Random frames in three backpressure stages.
    for (int stage = 0; stage < 3; stage++) begin
      int unsigned stage_start;
      case (stage)
        0: begin
          send_idle = 11;
          recv_idle = 52;
        end
        1: begin
          send_idle = 52;
          recv_idle = 11;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      stage_start = sent_pixels;
      while (sent_pixels - stage_start < STAGE_WORDS) run_segment();
    end

    // Oversized width saturates at the line size: part of a long row, then
    // a cut to four columns restarts the row and a random stretch follows.
    set_reg(CFG_HEIGHT, 13'd4);
    set_reg(CFG_WIDTH, 13'd8191);
    repeat (64) push_random();
    set_reg(CFG_WIDTH, 13'd4);
    run_segment();

    in_valid = 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("rgb_box_downscale_4x4_unit: match");
    end else begin
      $display("rgb_box_downscale_4x4_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> rgb_box_downscale_4x4_unit.f
+incdir+src
src/rbd_pkg.sv
src/rbd_ctrl.sv
src/rbd_datapath.sv
src/rbd_out_fifo.sv
src/rgb_box_downscale_4x4_unit.sv
dv/rgb_box_downscale_4x4_unit_tb.sv
